@@ hw/rtl/segarea_pkg.sv @@
// ----------------------------------------------------------------------------
// Segment area package
// Shared constants, codes and types for the grid-face segment area block.
// ----------------------------------------------------------------------------
package segarea_pkg;

    // Image geometry.
    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WIDTH_W     = 11;
    localparam int ROW_W       = 16;
    localparam int LINE_AW     = COL_W + 1;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);
    localparam logic [WIDTH_W-1:0] WIDTH_MIN   = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);

    // Segments and labels.
    localparam int MAX_SEGMENTS = 256;
    localparam int SEG_W        = 8;
    localparam int LABEL_W      = SEG_W + 1;

    // Arithmetic widths.
    localparam int COORD_BITS = 24;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DELTA_W    = PROD_W + 2;
    localparam int NORM_W     = 18;
    localparam int SUM_W      = 64;
    localparam int AREA_W     = 63;

    // Queue sizes.
    localparam int JOBQ_DEPTH = 16;
    localparam int JOBQ_AW    = 4;
    localparam int OUTQ_DEPTH = 16;
    localparam int OUTQ_AW    = 4;

    // Input operation codes.
    localparam logic [1:0] OP_PIXEL  = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Job kinds passed from the front end to the back end.
    localparam logic [1:0] JOB_ADD   = 2'd0;
    localparam logic [1:0] JOB_QUERY = 2'd1;
    localparam logic [1:0] JOB_CLEAR = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } point_t;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        point_t             pt;
    } line_word_t;

    // An accumulate carries a face vector; a query carries its normal in the low bits.
    typedef struct packed {
        logic [1:0]                kind;
        logic [SEG_W-1:0]          seg;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic signed [DELTA_W-1:0] dz;
    } job_t;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [SEG_W-1:0]  seg;
        logic              sat;
    } result_t;

endpackage

@@ hw/rtl/segarea_front.sv @@
// ----------------------------------------------------------------------------
// Segment area front end
// Accepts words, tracks the raster position, keeps two image lines and forms
// the face cross products of each interior pixel as accumulate jobs; queries and clears pass on as jobs.
// ----------------------------------------------------------------------------
module segarea_front
    import segarea_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [WIDTH_W-1:0]           width_cfg,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   operation,
    input  logic                         labelled,
    input  logic [SEG_W-1:0]             segment_id,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    input  logic signed [NORM_W-1:0]     normal_x,
    input  logic signed [NORM_W-1:0]     normal_y,
    input  logic signed [NORM_W-1:0]     normal_z,
    input  logic [JOBQ_AW:0]             jobq_count,
    output logic                         job_valid,
    output job_t                         job
);

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
    } vec_t;

    function automatic vec_t pdiff(input point_t a, input point_t b);
        vec_t r;
        r.x = DIFF_W'(a.x) - DIFF_W'(b.x);
        r.y = DIFF_W'(a.y) - DIFF_W'(b.y);
        r.z = DIFF_W'(a.z) - DIFF_W'(b.z);
        return r;
    endfunction

    logic                 accept;
    logic [WIDTH_W-1:0]   w_eff;
    logic [WIDTH_W-1:0]   col_plus;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [LABEL_W-1:0]   lab_in;
    point_t               pt_in;
    logic [LINE_AW-1:0]   addr_cur, addr_prv;
    logic                 face_pos;
    logic [2:0]           inflight;

    line_word_t           line_mem [2*MAX_WIDTH];
    line_word_t           rd_cur_reg, rd_prv_reg;

    logic                 s1_valid_reg;
    logic [1:0]           s1_op_reg;
    logic [SEG_W-1:0]     s1_seg_reg;
    logic [LABEL_W-1:0]   s1_lab_reg;
    point_t               s1_pt_reg;
    logic                 s1_face_reg;
    logic [3*NORM_W-1:0]  s1_norm_reg;

    line_word_t           ctr_reg, lft_reg, up_reg, dn_reg;
    logic [LABEL_W-1:0]   ul_lab_reg;

    logic [LABEL_W-1:0]   fl;
    logic [2:0]           key;
    logic                 face_ok, corner;
    logic                 s2_valid_next;
    logic [1:0]           s2_kind_next;
    vec_t                 u_next, v_next, cu_next, cv_next;

    logic                 s2_valid_reg;
    logic [1:0]           s2_kind_reg;
    logic [SEG_W-1:0]     s2_seg_reg;
    vec_t                 u_reg, v_reg, cu_reg, cv_reg;
    logic [3*NORM_W-1:0]  s2_norm_reg;

    logic                 s3_valid_reg;
    logic [1:0]           s3_kind_reg;
    logic [SEG_W-1:0]     s3_seg_reg;
    logic signed [PROD_W-1:0] prod_reg [12];
    logic [3*NORM_W-1:0]  s3_norm_reg;

    logic                 s4_valid_reg;
    job_t                 s4_job_reg, s4_job_next;

    // Back-pressure counts the jobs still in flight towards the queue.
    assign inflight = 3'(s1_valid_reg) + 3'(s2_valid_reg) + 3'(s3_valid_reg)
                    + 3'(s4_valid_reg);
    assign full     = ((JOBQ_AW+2)'(jobq_count) + (JOBQ_AW+2)'(inflight))
                      >= (JOBQ_AW+2)'(JOBQ_DEPTH);
    assign accept   = push && !full;

    // Effective width and raster position.
    always_comb
    begin
        if (width_cfg < WIDTH_MIN)
            w_eff = WIDTH_MIN;
        else if (width_cfg > WIDTH_MAX)
            w_eff = WIDTH_MAX;
        else
            w_eff = width_cfg;
        col_plus = WIDTH_W'(col_reg) + WIDTH_W'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (accept && operation == OP_CLEAR)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept && operation == OP_PIXEL)
        begin
            if (col_plus >= w_eff)
            begin
                col_next = '0;
                if (row_reg != '1)
                    row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_plus[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign lab_in   = labelled ? {1'b1, segment_id} : '0;
    assign pt_in    = '{x: coord_x, y: coord_y, z: coord_z};
    assign addr_cur = {row_reg[0], col_reg};
    assign addr_prv = {~row_reg[0], col_reg};
    assign face_pos = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2))
                   && (WIDTH_W'(col_reg) <= (w_eff - WIDTH_W'(1)));

    // Line store: the current parity half holds the row two up, the other the row above.
    always_ff @(posedge clk)
    begin
        if (accept && operation == OP_PIXEL)
        begin
            rd_cur_reg         <= line_mem[addr_cur];
            rd_prv_reg         <= line_mem[addr_prv];
            line_mem[addr_cur] <= '{label: lab_in, pt: pt_in};
        end
    end

    // Stage one: the accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept && (operation != OP_UNUSED);
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg   <= operation;
        s1_seg_reg  <= segment_id;
        s1_lab_reg  <= lab_in;
        s1_pt_reg   <= pt_in;
        s1_face_reg <= face_pos;
        s1_norm_reg <= {normal_x, normal_y, normal_z};
    end

    // Window registers shift along the row with every pixel.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_op_reg == OP_PIXEL)
        begin
            lft_reg    <= ctr_reg;
            ctr_reg    <= rd_prv_reg;
            ul_lab_reg <= up_reg.label;
            up_reg     <= rd_cur_reg;
            dn_reg     <= '{label: s1_lab_reg, pt: s1_pt_reg};
        end
    end

    // Face classification and edge vectors.
    always_comb
    begin
        fl      = ctr_reg.label;
        face_ok = s1_face_reg && fl[LABEL_W-1];
        key     = {dn_reg.label == fl, s1_lab_reg == fl, rd_prv_reg.label == fl};
        corner  = (ul_lab_reg != fl) && (lft_reg.label == fl) && (up_reg.label == fl);
        u_next  = '0;
        v_next  = '0;
        case (key)
            3'd7:
            begin
                u_next = pdiff(s1_pt_reg, ctr_reg.pt);
                v_next = pdiff(rd_prv_reg.pt, dn_reg.pt);
            end
            3'd3:
            begin
                u_next = pdiff(s1_pt_reg, ctr_reg.pt);
                v_next = pdiff(rd_prv_reg.pt, ctr_reg.pt);
            end
            3'd5:
            begin
                u_next = pdiff(dn_reg.pt, ctr_reg.pt);
                v_next = pdiff(rd_prv_reg.pt, ctr_reg.pt);
            end
            3'd6:
            begin
                u_next = pdiff(dn_reg.pt, ctr_reg.pt);
                v_next = pdiff(s1_pt_reg, ctr_reg.pt);
            end
            default:
            begin
                u_next = '0;
                v_next = '0;
            end
        endcase
        cu_next = corner ? pdiff(up_reg.pt, ctr_reg.pt) : '0;
        cv_next = corner ? pdiff(lft_reg.pt, ctr_reg.pt) : '0;
        case (s1_op_reg)
            OP_PIXEL:
            begin
                s2_kind_next  = JOB_ADD;
                s2_valid_next = s1_valid_reg && face_ok;
            end
            OP_QUERY:
            begin
                s2_kind_next  = JOB_QUERY;
                s2_valid_next = s1_valid_reg;
            end
            OP_CLEAR:
            begin
                s2_kind_next  = JOB_CLEAR;
                s2_valid_next = s1_valid_reg;
            end
            default:
            begin
                s2_kind_next  = JOB_CLEAR;
                s2_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Stage two registers the vectors; stage three the twelve products.
    always_ff @(posedge clk)
    begin
        s2_kind_reg  <= s2_kind_next;
        s2_seg_reg   <= (s1_op_reg == OP_PIXEL) ? fl[SEG_W-1:0] : s1_seg_reg;
        u_reg        <= u_next;
        v_reg        <= v_next;
        cu_reg       <= cu_next;
        cv_reg       <= cv_next;
        s2_norm_reg  <= s1_norm_reg;

        s3_kind_reg  <= s2_kind_reg;
        s3_seg_reg   <= s2_seg_reg;
        s3_norm_reg  <= s2_norm_reg;
        prod_reg[0]  <= u_reg.y * v_reg.z;
        prod_reg[1]  <= u_reg.z * v_reg.y;
        prod_reg[2]  <= u_reg.z * v_reg.x;
        prod_reg[3]  <= u_reg.x * v_reg.z;
        prod_reg[4]  <= u_reg.x * v_reg.y;
        prod_reg[5]  <= u_reg.y * v_reg.x;
        prod_reg[6]  <= cu_reg.y * cv_reg.z;
        prod_reg[7]  <= cu_reg.z * cv_reg.y;
        prod_reg[8]  <= cu_reg.z * cv_reg.x;
        prod_reg[9]  <= cu_reg.x * cv_reg.z;
        prod_reg[10] <= cu_reg.x * cv_reg.y;
        prod_reg[11] <= cu_reg.y * cv_reg.x;
    end

    // Stage four: summed cross products, or the query normal.
    always_comb
    begin
        s4_job_next.kind = s3_kind_reg;
        s4_job_next.seg  = s3_seg_reg;
        if (s3_kind_reg == JOB_QUERY)
        begin
            s4_job_next.dx = DELTA_W'($signed(s3_norm_reg[3*NORM_W-1:2*NORM_W]));
            s4_job_next.dy = DELTA_W'($signed(s3_norm_reg[2*NORM_W-1:NORM_W]));
            s4_job_next.dz = DELTA_W'($signed(s3_norm_reg[NORM_W-1:0]));
        end
        else
        begin
            s4_job_next.dx = DELTA_W'(prod_reg[0]) - DELTA_W'(prod_reg[1])
                           + DELTA_W'(prod_reg[6]) - DELTA_W'(prod_reg[7]);
            s4_job_next.dy = DELTA_W'(prod_reg[2]) - DELTA_W'(prod_reg[3])
                           + DELTA_W'(prod_reg[8]) - DELTA_W'(prod_reg[9]);
            s4_job_next.dz = DELTA_W'(prod_reg[4]) - DELTA_W'(prod_reg[5])
                           + DELTA_W'(prod_reg[10]) - DELTA_W'(prod_reg[11]);
        end
    end

    always_ff @(posedge clk)
    begin
        s4_job_reg <= s4_job_next;
    end

    assign job_valid = s4_valid_reg;
    assign job       = s4_job_reg;

endmodule

@@ hw/rtl/segarea_jobq.sv @@
// ----------------------------------------------------------------------------
// Segment area job queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module segarea_jobq
    import segarea_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  job_t             push_job,
    input  logic             pop,
    output logic             avail,
    output job_t             head,
    output logic [JOBQ_AW:0] count
);

    job_t               mem [JOBQ_DEPTH];
    logic [JOBQ_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [JOBQ_AW:0]   count_reg, count_next;

    // Occupancy tracking.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (JOBQ_AW+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (JOBQ_AW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + JOBQ_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + JOBQ_AW'(1);
            count_reg <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    assign avail = (count_reg != '0);
    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < (JOBQ_AW+1)'(JOBQ_DEPTH)))
        else $error("job queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("job queue read while empty");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && pop) |=> (count_reg == $past(count_reg)))
        else $error("job queue count moved on simultaneous push and pop");
`endif

endmodule

@@ hw/rtl/segarea_back.sv @@
// ----------------------------------------------------------------------------
// Segment area back end
// Runs jobs against the per-segment accumulators and computes query areas
// into a result queue.
// ----------------------------------------------------------------------------
module segarea_back
    import segarea_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_avail,
    input  job_t              job,
    output logic              job_pop,
    output logic              empty,
    input  logic              pop,
    output logic [AREA_W-1:0] area,
    output logic [SEG_W-1:0]  area_segment,
    output logic              saturated
);

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } sum_t;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam int TERM_W = SUM_W + NORM_W + 2;
    localparam int TOT_W  = TERM_W + 2;

    function automatic logic [SUM_W:0] sat_add(input logic signed [SUM_W-1:0] a,
                                               input logic signed [DELTA_W-1:0] b);
        logic signed [SUM_W:0] s;
        s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
        if (s[SUM_W] != s[SUM_W-1])
            return {1'b1, s[SUM_W] ? SUM_MIN : SUM_MAX};
        return {1'b0, s[SUM_W-1:0]};
    endfunction

    logic                     out_push, out_pop;
    logic [OUTQ_AW:0]         pend_reg, pend_next;
    logic [OUTQ_AW:0]         out_count_reg, out_count_next;
    logic [OUTQ_AW-1:0]       out_wr_reg, out_rd_reg;
    result_t                  outq_mem [OUTQ_DEPTH];
    result_t                  out_word;

    sum_t                     sum_mem [MAX_SEGMENTS];
    sum_t                     sum_rd_reg;
    logic                     b1_valid_reg;
    job_t                     b1_job_reg;
    logic [MAX_SEGMENTS-1:0]  row_valid_reg, ovf_reg;
    logic                     fwd_valid_reg;
    logic [SEG_W-1:0]         fwd_seg_reg;
    sum_t                     fwd_sum_reg;
    sum_t                     cur_sum, new_sum;
    logic [SUM_W:0]           add_x, add_y, add_z;
    logic                     add_ovf;
    logic                     b1_add, b1_query, b1_clear;

    logic [6:1]               qv_reg;
    logic signed [SUM_W-1:0]  q1_s_reg [3];
    logic signed [NORM_W-1:0] q1_n_reg [3];
    logic [SUM_W-1:0]         q2_ms_reg [3];
    logic [NORM_W-1:0]        q2_mn_reg [3];
    logic [2:0]               q2_neg_reg, q3_neg_reg;
    logic [SUM_W/2+NORM_W-1:0] q3_pl_reg [3];
    logic [SUM_W/2+NORM_W-1:0] q3_ph_reg [3];
    logic signed [TERM_W-1:0] q4_term_reg [3];
    logic signed [TOT_W-1:0]  q5_tot_reg;
    logic [TOT_W-1:0]         q6_abs_reg;
    logic [TOT_W:0]           q7_rnd;
    logic [SEG_W-1:0]         q_seg_reg [1:6];
    logic [6:1]               q_ovf_reg;

    // A query is taken only while the result queue has a free place reserved for it.
    assign job_pop  = job_avail
                   && ((job.kind != JOB_QUERY) || (pend_reg < (OUTQ_AW+1)'(OUTQ_DEPTH)));
    assign out_pop  = pop && !empty;
    assign out_push = qv_reg[6];

    always_comb
    begin
        pend_next = pend_reg;
        if ((job_pop && job.kind == JOB_QUERY) && !out_pop)
            pend_next = pend_reg + (OUTQ_AW+1)'(1);
        else if (!(job_pop && job.kind == JOB_QUERY) && out_pop)
            pend_next = pend_reg - (OUTQ_AW+1)'(1);
        out_count_next = out_count_reg;
        if (out_push && !out_pop)
            out_count_next = out_count_reg + (OUTQ_AW+1)'(1);
        else if (out_pop && !out_push)
            out_count_next = out_count_reg - (OUTQ_AW+1)'(1);
    end

    // Accumulator memory: read on pop, written back in the cycle after.
    always_ff @(posedge clk)
    begin
        if (job_pop)
            sum_rd_reg <= sum_mem[job.seg];
        if (b1_add)
            sum_mem[b1_job_reg.seg] <= new_sum;
        b1_job_reg <= job;
    end

    assign b1_add   = b1_valid_reg && (b1_job_reg.kind == JOB_ADD);
    assign b1_query = b1_valid_reg && (b1_job_reg.kind == JOB_QUERY);
    assign b1_clear = b1_valid_reg && (b1_job_reg.kind == JOB_CLEAR);

    // The write of the previous job is forwarded; rows not written this frame read zero.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_seg_reg == b1_job_reg.seg))
            cur_sum = fwd_sum_reg;
        else if (row_valid_reg[b1_job_reg.seg])
            cur_sum = sum_rd_reg;
        else
            cur_sum = '0;
        add_x     = sat_add(cur_sum.x, b1_job_reg.dx);
        add_y     = sat_add(cur_sum.y, b1_job_reg.dy);
        add_z     = sat_add(cur_sum.z, b1_job_reg.dz);
        new_sum.x = add_x[SUM_W-1:0];
        new_sum.y = add_y[SUM_W-1:0];
        new_sum.z = add_z[SUM_W-1:0];
        add_ovf   = add_x[SUM_W] || add_y[SUM_W] || add_z[SUM_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            row_valid_reg <= '0;
            ovf_reg       <= '0;
            fwd_valid_reg <= 1'b0;
            qv_reg        <= '0;
            pend_reg      <= '0;
            out_count_reg <= '0;
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
        end
        else
        begin
            b1_valid_reg <= job_pop;
            if (b1_clear)
            begin
                row_valid_reg <= '0;
                ovf_reg       <= '0;
            end
            else if (b1_add)
            begin
                row_valid_reg[b1_job_reg.seg] <= 1'b1;
                if (add_ovf)
                    ovf_reg[b1_job_reg.seg] <= 1'b1;
            end
            fwd_valid_reg <= b1_add;
            qv_reg        <= {qv_reg[5:1], b1_query};
            pend_reg      <= pend_next;
            out_count_reg <= out_count_next;
            if (out_push)
                out_wr_reg <= out_wr_reg + OUTQ_AW'(1);
            if (out_pop)
                out_rd_reg <= out_rd_reg + OUTQ_AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_seg_reg <= b1_job_reg.seg;
        fwd_sum_reg <= new_sum;
    end

    // Area pipeline: magnitudes, split products, signed terms, sum, absolute value, rounding.
    always_ff @(posedge clk)
    begin
        q1_s_reg[0] <= cur_sum.x;
        q1_s_reg[1] <= cur_sum.y;
        q1_s_reg[2] <= cur_sum.z;
        q1_n_reg[0] <= b1_job_reg.dx[NORM_W-1:0];
        q1_n_reg[1] <= b1_job_reg.dy[NORM_W-1:0];
        q1_n_reg[2] <= b1_job_reg.dz[NORM_W-1:0];
        q_seg_reg[1] <= b1_job_reg.seg;
        q_ovf_reg[1] <= ovf_reg[b1_job_reg.seg];
        for (int i = 0; i < 3; i++)
        begin
            q2_ms_reg[i]  <= q1_s_reg[i][SUM_W-1] ? (~q1_s_reg[i] + SUM_W'(1)) : q1_s_reg[i];
            q2_mn_reg[i]  <= q1_n_reg[i][NORM_W-1] ? (~q1_n_reg[i] + NORM_W'(1))
                                                   : q1_n_reg[i];
            q2_neg_reg[i] <= q1_s_reg[i][SUM_W-1] ^ q1_n_reg[i][NORM_W-1];
            q3_pl_reg[i]  <= (SUM_W/2+NORM_W)'(q2_ms_reg[i][SUM_W/2-1:0])
                           * (SUM_W/2+NORM_W)'(q2_mn_reg[i]);
            q3_ph_reg[i]  <= (SUM_W/2+NORM_W)'(q2_ms_reg[i][SUM_W-1:SUM_W/2])
                           * (SUM_W/2+NORM_W)'(q2_mn_reg[i]);
            q4_term_reg[i] <= q3_neg_reg[i]
                ? -({q3_ph_reg[i], {(SUM_W/2){1'b0}}} + TERM_W'(q3_pl_reg[i]))
                :  ({q3_ph_reg[i], {(SUM_W/2){1'b0}}} + TERM_W'(q3_pl_reg[i]));
        end
        q3_neg_reg <= q2_neg_reg;
        q5_tot_reg <= TOT_W'(q4_term_reg[0]) + TOT_W'(q4_term_reg[1])
                    + TOT_W'(q4_term_reg[2]);
        q6_abs_reg <= q5_tot_reg[TOT_W-1] ? (~q5_tot_reg + TOT_W'(1)) : q5_tot_reg;
        for (int k = 2; k <= 6; k++)
        begin
            q_seg_reg[k] <= q_seg_reg[k-1];
            q_ovf_reg[k] <= q_ovf_reg[k-1];
        end
    end

    // Round half up at bit 17; anything from 2^80 on saturates.
    always_comb
    begin
        q7_rnd = (TOT_W+1)'(q6_abs_reg) + (TOT_W+1)'(32'h1_0000);
        if (q7_rnd[TOT_W:AREA_W+17] != '0)
        begin
            out_word.area = '1;
            out_word.sat  = 1'b1;
        end
        else
        begin
            out_word.area = q7_rnd[AREA_W+16:17];
            out_word.sat  = q_ovf_reg[6];
        end
        out_word.seg = q_seg_reg[6];
    end

    // Result queue; qv_reg[6] marks the absolute value stage as valid.
    always_ff @(posedge clk)
    begin
        if (out_push)
            outq_mem[out_wr_reg] <= out_word;
    end

    assign empty        = (out_count_reg == '0);
    assign area         = outq_mem[out_rd_reg].area;
    assign area_segment = outq_mem[out_rd_reg].seg;
    assign saturated    = outq_mem[out_rd_reg].sat;

`ifndef ASSERT_OFF
    a_outq_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (out_count_reg < (OUTQ_AW+1)'(OUTQ_DEPTH)))
        else $error("result queue written while full");
    a_reserve_cover: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg >= out_count_reg)
        else $error("result reservations fewer than stored results");
    a_clear_rows: assert property (@(posedge clk) disable iff (!rst_n)
        b1_clear |=> ((row_valid_reg == '0) && (ovf_reg == '0)))
        else $error("accumulator rows survived a clear");
`endif

endmodule

@@ hw/rtl/segment_area_by_grid_faces.sv @@
// ----------------------------------------------------------------------------
// Segment area by grid faces
// Sums the surface of labelled segments of an organised depth image and
// reports a segment's area projected on a given normal.
// ----------------------------------------------------------------------------
// Takes one word per clock in steady state while full is low: pixels, area
// queries and frame clears may follow each other back to back. A pixel's
// face contribution and a query's area pass in order through the four-stage
// cross-product pipeline, the job queue and the accumulator read-modify-write
// with bypass; a query then goes on through the six-stage area pipeline to
// the result queue. Sixteen results can wait to be popped before queries
// stall the input. Write image_width only while the block is idle.
module segment_area_by_grid_faces
    import segarea_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [WIDTH_W-1:0]           cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   operation,
    input  logic                         labelled,
    input  logic [SEG_W-1:0]             segment_id,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    input  logic signed [NORM_W-1:0]     normal_x,
    input  logic signed [NORM_W-1:0]     normal_y,
    input  logic signed [NORM_W-1:0]     normal_z,
    output logic                         empty,
    input  logic                         pop,
    output logic [AREA_W-1:0]            area,
    output logic [SEG_W-1:0]             area_segment,
    output logic                         saturated
);

    logic [WIDTH_W-1:0] image_width_reg;
    logic               job_valid, job_pop, job_avail;
    job_t               front_job, head_job;
    logic [JOBQ_AW:0]   jobq_count;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            image_width_reg <= WIDTH_RESET;
        else if (cfg_write)
            image_width_reg <= cfg_data;
    end

    segarea_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .width_cfg  (image_width_reg),
        .push       (push),
        .full       (full),
        .operation  (operation),
        .labelled   (labelled),
        .segment_id (segment_id),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z),
        .jobq_count (jobq_count),
        .job_valid  (job_valid),
        .job        (front_job)
    );

    segarea_jobq u_jobq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_valid),
        .push_job (front_job),
        .pop      (job_pop),
        .avail    (job_avail),
        .head     (head_job),
        .count    (jobq_count)
    );

    segarea_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_avail    (job_avail),
        .job          (head_job),
        .job_pop      (job_pop),
        .empty        (empty),
        .pop          (pop),
        .area         (area),
        .area_segment (area_segment),
        .saturated    (saturated)
    );

endmodule
